// ===== hw/rtl/mris_pkg.sv =====
`timescale 1ns / 1ps

package mris_pkg;

    // Fixed field widths of the stream items
    localparam int LEN_BITS   = 16;
    localparam int COUNT_BITS = 17;
    localparam int OPOS_BITS  = 16;

    // Operation applied to a cell of the stack row
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'b00,
        CELL_PUSH       = 2'b01,
        CELL_POP        = 2'b10,
        CELL_SET_LETTER = 2'b11
    } cell_op_t;

    // Control sequencer states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

endpackage

// ===== hw/rtl/mris_cell.sv =====
`timescale 1ns / 1ps

// One stack entry. Push takes the entry from the cell above, pop takes the
// entry from the cell below; set-letter rewrites only the letter.
module mris_cell #(
    parameter int START_BITS  = 16,
    parameter int LETTER_BITS = 16
) (
    input  logic                           aclk,
    input  mris_pkg::cell_op_t             op,
    input  logic [mris_pkg::LEN_BITS-1:0]  up_len,
    input  logic [START_BITS-1:0]          up_start,
    input  logic [LETTER_BITS-1:0]         up_letter,
    input  logic [mris_pkg::LEN_BITS-1:0]  dn_len,
    input  logic [START_BITS-1:0]          dn_start,
    input  logic [LETTER_BITS-1:0]         dn_letter,
    output logic [mris_pkg::LEN_BITS-1:0]  q_len,
    output logic [START_BITS-1:0]          q_start,
    output logic [LETTER_BITS-1:0]         q_letter
);

    logic [mris_pkg::LEN_BITS-1:0] len_reg, len_next;
    logic [START_BITS-1:0]         start_reg, start_next;
    logic [LETTER_BITS-1:0]        letter_reg, letter_next;

    always_comb begin
        len_next    = len_reg;
        start_next  = start_reg;
        letter_next = letter_reg;
        case (op)
            mris_pkg::CELL_PUSH: begin
                len_next    = up_len;
                start_next  = up_start;
                letter_next = up_letter;
            end
            mris_pkg::CELL_POP: begin
                len_next    = dn_len;
                start_next  = dn_start;
                letter_next = dn_letter;
            end
            mris_pkg::CELL_SET_LETTER: begin
                letter_next = up_letter;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        start_reg  <= start_next;
        letter_reg <= letter_next;
    end

    assign q_len    = len_reg;
    assign q_start  = start_reg;
    assign q_letter = letter_reg;

endmodule

// ===== hw/rtl/maximal_repeat_interval_stack.sv =====
`timescale 1ns / 1ps

// Maximal repeat finder. Feed the LCP value and BWT symbol of each
// suffix-array position in order; a transfer with first_item set opens a
// sequence and a transfer with tlast (end_of_sequence) set closes it and flushes
// every open interval. Each reported repeat leaves as one result transfer,
// and tlast marks the last result caused by one input transfer. The open
// intervals sit in a row of STACK_DEPTH cells whose top is cell 0; a push
// shifts the row down, a pop shifts it up, one entry per cycle while the
// result channel does not stall. A first item only pushes its interval;
// any other item is accepted, pops every interval it closes, then pushes
// or merges; the loop waits while m_tready is low and a result must move
// out. s_tready stays low until the loop ends. A push that finds the row
// full is dropped and sets the sticky stack_overflowed flag until the
// next first item. No clearing pass is needed after reset.
module maximal_repeat_interval_stack #(
    parameter int STACK_DEPTH   = 64,
    parameter int POSITION_BITS = 16,
    parameter int SYMBOL_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] lcp_value, [31:16] symbol
    input  logic [0:0]  s_tuser,   // [0] first_item
    input  logic        s_tlast,   // end_of_sequence
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] repeat_length,
                                   // [32:16] occurrence_count,
                                   // [48:33] first_position, [55:49] zero
    output logic [0:0]  m_tuser,   // [0] stack_overflowed
    output logic        m_tlast,   // last_of_run
    // Configuration: min_length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int LB         = mris_pkg::LEN_BITS;
    localparam int CB         = mris_pkg::COUNT_BITS;
    localparam int OB         = mris_pkg::OPOS_BITS;
    localparam int FILL_BITS  = $clog2(STACK_DEPTH + 1);

    // Keep a common letter, or zero when the left contexts differ
    function automatic logic [SYMBOL_BITS-1:0] left_equal(
        input logic [SYMBOL_BITS-1:0] a,
        input logic [SYMBOL_BITS-1:0] b
    );
        left_equal = ((a == '0) || (a != b)) ? '0 : a;
    endfunction

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic [LB-1:0]          in_lcp;
    logic [63:0]            in_sym_wide;
    logic [SYMBOL_BITS-1:0] in_sym;
    logic                   in_first;
    logic                   in_end;
    logic                   in_xfer;

    assign in_lcp      = s_tdata[15:0];
    assign in_sym_wide = 64'(s_tdata[31:16]);
    assign in_sym      = in_sym_wide[SYMBOL_BITS-1:0];
    assign in_first    = s_tuser[0];
    assign in_end      = s_tlast;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    mris_pkg::state_t state_reg, state_next;

    logic [FILL_BITS-1:0]     fill_reg, fill_next;
    logic [SYMBOL_BITS-1:0]   prev_reg, prev_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     ovf_reg, ovf_next;
    logic [LB-1:0]            min_len_reg, min_len_next;

    // Working copy of the item under the pop loop
    logic [LB-1:0]            lcp_reg, lcp_next;
    logic [SYMBOL_BITS-1:0]   letter_reg, letter_next;
    logic [POSITION_BITS-1:0] stpos_reg, stpos_next;
    logic                     eos_reg, eos_next;

    // Pending result: held until we know whether another one follows
    logic                     pend_valid_reg, pend_valid_next;
    logic [LB-1:0]            pend_len_reg, pend_len_next;
    logic [CB-1:0]            pend_cnt_reg, pend_cnt_next;
    logic [OB-1:0]            pend_pos_reg, pend_pos_next;
    logic                     pend_ovf_reg, pend_ovf_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [LB-1:0]            out_len_reg, out_len_next;
    logic [CB-1:0]            out_cnt_reg, out_cnt_next;
    logic [OB-1:0]            out_pos_reg, out_pos_next;
    logic                     out_ovf_reg, out_ovf_next;
    logic                     out_last_reg, out_last_next;

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    logic [LB-1:0]            q_len    [STACK_DEPTH];
    logic [POSITION_BITS-1:0] q_start  [STACK_DEPTH];
    logic [SYMBOL_BITS-1:0]   q_letter [STACK_DEPTH];

    mris_pkg::cell_op_t       row_op;
    logic [LB-1:0]            top_len_in;
    logic [POSITION_BITS-1:0] top_start_in;
    logic [SYMBOL_BITS-1:0]   top_letter_in;
    logic [SYMBOL_BITS-1:0]   pop_letter;

    // On a pop the new top merges its letter with the one leaving
    assign pop_letter = left_equal(q_letter[0], q_letter[1]);

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            mris_pkg::cell_op_t       cop;
            logic [LB-1:0]            ul;
            logic [POSITION_BITS-1:0] us;
            logic [SYMBOL_BITS-1:0]   ut;
            logic [LB-1:0]            dl;
            logic [POSITION_BITS-1:0] ds;
            logic [SYMBOL_BITS-1:0]   dt;

            if (gi == 0) begin : g_top
                assign cop = row_op;
                assign ul  = top_len_in;
                assign us  = top_start_in;
                assign ut  = top_letter_in;
                assign dl  = q_len[1];
                assign ds  = q_start[1];
                assign dt  = pop_letter;
            end else begin : g_body
                // Letter rewrites touch only the top cell
                assign cop = (row_op == mris_pkg::CELL_SET_LETTER) ?
                             mris_pkg::CELL_HOLD : row_op;
                assign ul  = q_len[gi-1];
                assign us  = q_start[gi-1];
                assign ut  = q_letter[gi-1];
                if (gi == STACK_DEPTH - 1) begin : g_bottom
                    assign dl = '0;
                    assign ds = '0;
                    assign dt = '0;
                end else begin : g_mid
                    assign dl = q_len[gi+1];
                    assign ds = q_start[gi+1];
                    assign dt = q_letter[gi+1];
                end
            end

            mris_cell #(
                .START_BITS  (POSITION_BITS),
                .LETTER_BITS (SYMBOL_BITS)
            ) u_cell (
                .aclk      (aclk),
                .op        (cop),
                .up_len    (ul),
                .up_start  (us),
                .up_letter (ut),
                .dn_len    (dl),
                .dn_start  (ds),
                .dn_letter (dt),
                .q_len     (q_len[gi]),
                .q_start   (q_start[gi]),
                .q_letter  (q_letter[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Result fields of the top interval
    // ------------------------------------------------------------------
    logic [POSITION_BITS-1:0] diff;
    logic [POSITION_BITS:0]   cnt_wide;
    logic [63:0]              cnt_ext;
    logic [63:0]              spos_ext;
    logic                     fill_nz;
    logic                     fill_full;
    logic                     top_gt;
    logic                     top_eq;
    logic                     report;
    logic                     out_free;
    logic                     need_out;
    logic                     stall;

    // An empty difference means the interval spans the whole position range
    assign diff     = pos_reg - q_start[0];
    assign cnt_wide = {(diff == '0), diff};
    assign cnt_ext  = 64'(cnt_wide);
    assign spos_ext = 64'(q_start[0]);

    assign fill_nz   = (fill_reg != '0);
    assign fill_full = (fill_reg == FILL_BITS'(STACK_DEPTH));
    assign top_gt    = fill_nz && (q_len[0] > lcp_reg);
    assign top_eq    = fill_nz && (q_len[0] == lcp_reg);
    assign report    = (q_letter[0] == '0) && (q_len[0] >= min_len_reg);
    assign out_free  = !out_valid_reg || m_tready;

    // The pending result must move out when a newer one replaces it or the
    // loop closes
    assign need_out = (state_reg == mris_pkg::ST_POP) && pend_valid_reg &&
                      (top_gt ? report : 1'b1);
    assign stall    = need_out && !out_free;

    assign s_tready  = (state_reg == mris_pkg::ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        logic [SYMBOL_BITS-1:0] sym_eff;

        state_next      = state_reg;
        fill_next       = fill_reg;
        prev_next       = prev_reg;
        pos_next        = pos_reg;
        ovf_next        = ovf_reg;
        min_len_next    = min_len_reg;
        lcp_next        = lcp_reg;
        letter_next     = letter_reg;
        stpos_next      = stpos_reg;
        eos_next        = eos_reg;
        pend_valid_next = pend_valid_reg;
        pend_len_next   = pend_len_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_pos_next   = pend_pos_reg;
        pend_ovf_next   = pend_ovf_reg;
        out_valid_next  = out_valid_reg;
        out_len_next    = out_len_reg;
        out_cnt_next    = out_cnt_reg;
        out_pos_next    = out_pos_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        row_op          = mris_pkg::CELL_HOLD;
        top_len_in      = lcp_reg;
        top_start_in    = stpos_reg;
        top_letter_in   = letter_reg;
        sym_eff         = in_end ? '0 : in_sym;

        if (cfg_valid && cfg_ready) begin
            min_len_next = cfg_data;
        end

        // Drop the output once taken
        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        // Advance the pending result into the output register
        if (need_out && !stall) begin
            out_valid_next = 1'b1;
            out_len_next   = pend_len_reg;
            out_cnt_next   = pend_cnt_reg;
            out_pos_next   = pend_pos_reg;
            out_ovf_next   = pend_ovf_reg;
            out_last_next  = !top_gt;
        end

        case (state_reg)
            mris_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (in_first) begin
                        // Open a sequence with the interval (0, 0, symbol)
                        row_op        = mris_pkg::CELL_PUSH;
                        top_len_in    = '0;
                        top_start_in  = '0;
                        top_letter_in = in_sym;
                        fill_next     = FILL_BITS'(1);
                        ovf_next      = 1'b0;
                        pos_next      = '0;
                        prev_next     = in_sym;
                    end else begin
                        lcp_next    = in_end ? '0 : in_lcp;
                        letter_next = left_equal(prev_reg, sym_eff);
                        prev_next   = sym_eff;
                        stpos_next  = pos_reg;
                        pos_next    = pos_reg + POSITION_BITS'(1);
                        eos_next    = in_end;
                        state_next  = mris_pkg::ST_POP;
                    end
                end
            end
            mris_pkg::ST_POP: begin
                if (!stall) begin
                    if (top_gt) begin
                        // Close the top interval
                        row_op      = mris_pkg::CELL_POP;
                        fill_next   = fill_reg - FILL_BITS'(1);
                        stpos_next  = q_start[0];
                        letter_next = left_equal(q_letter[0], letter_reg);
                        if (report) begin
                            pend_valid_next = 1'b1;
                            pend_len_next   = q_len[0];
                            pend_cnt_next   = cnt_ext[CB-1:0];
                            pend_pos_next   = spos_ext[OB-1:0];
                            pend_ovf_next   = ovf_reg;
                        end
                    end else begin
                        pend_valid_next = 1'b0;
                        if (top_eq) begin
                            // Same length: merge into the open interval
                            row_op        = mris_pkg::CELL_SET_LETTER;
                            top_letter_in = left_equal(q_letter[0], letter_reg);
                        end else if (fill_full) begin
                            ovf_next = 1'b1;
                        end else begin
                            row_op    = mris_pkg::CELL_PUSH;
                            fill_next = fill_reg + FILL_BITS'(1);
                        end
                        if (eos_reg) begin
                            fill_next = '0;
                        end
                        state_next = mris_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = mris_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mris_pkg::ST_IDLE;
            fill_reg       <= '0;
            prev_reg       <= '0;
            pos_reg        <= '0;
            ovf_reg        <= 1'b0;
            min_len_reg    <= LB'(1);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            prev_reg       <= prev_next;
            pos_reg        <= pos_next;
            ovf_reg        <= ovf_next;
            min_len_reg    <= min_len_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        lcp_reg      <= lcp_next;
        letter_reg   <= letter_next;
        stpos_reg    <= stpos_next;
        eos_reg      <= eos_next;
        pend_len_reg <= pend_len_next;
        pend_cnt_reg <= pend_cnt_next;
        pend_pos_reg <= pend_pos_next;
        pend_ovf_reg <= pend_ovf_next;
        out_len_reg  <= out_len_next;
        out_cnt_reg  <= out_cnt_next;
        out_pos_reg  <= out_pos_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Result packing
    // ------------------------------------------------------------------
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'd0, out_pos_reg, out_cnt_reg, out_len_reg};
    assign m_tuser[0] = out_ovf_reg;
    assign m_tlast    = out_last_reg;

endmodule
